@@ rtl/core/sfd_pkg.sv @@
package sfd_pkg;

  // Fixed field widths of the item and result streams.
  localparam int OP_W          = 2;
  localparam int SYM_W         = 8;
  localparam int ENTRY_COUNT_W = 31;
  localparam int S_TDATA_W     = 40;
  localparam int S_TUSER_W     = 2;
  localparam int M_TDATA_W     = 8;
  localparam int M_TUSER_W     = 1;

  localparam int DEF_MAX_SYMBOLS = 256;
  localparam int DEF_SUM_BITS    = 40;

  // Opcode values of an incoming request.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BASE_RD,
    ST_TOT_RD,
    ST_TOT_USE,
    ST_PROBE_RD,
    ST_PROBE_USE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;       // capture the accepted request
    logic clear;      // empty the table
    logic append;     // store one entry
    logic fix_range;  // reset a stale range to the full table
    logic rd_base;    // read prefix sum below range_low
    logic rd_tot;     // latch base, read prefix sum at range_high
    logic ld_tot;     // latch half of the range total, start the search
    logic rd_probe;   // read prefix sum at the probe index
    logic ld_probe;   // narrow the search window
    logic step;       // apply the code bit to the range
    logic rd_sym;     // read the symbol at range_low
    logic emit;       // load the output register
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            size_lt2;
    logic            full;
    logic            search_done;
    logic            leaf;
    logic            out_free;
  } sts_t;

endpackage

@@ rtl/core/sfd_ctrl.sv @@
module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
          OP_APPEND: begin
            if (sts.full) begin
              state_next = ST_EMIT;
            end else begin
              cmd.append = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_DECODE: begin
            if (sts.size_lt2) begin
              state_next = ST_IDLE;
            end else begin
              cmd.fix_range = 1'b1;
              state_next    = ST_BASE_RD;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_BASE_RD: begin
        cmd.rd_base = 1'b1;
        state_next  = ST_TOT_RD;
      end
      ST_TOT_RD: begin
        cmd.rd_tot = 1'b1;
        state_next = ST_TOT_USE;
      end
      ST_TOT_USE: begin
        cmd.ld_tot = 1'b1;
        state_next = ST_PROBE_RD;
      end
      ST_PROBE_RD: begin
        if (sts.search_done) begin
          cmd.step   = 1'b1;
          state_next = ST_CHECK;
        end else begin
          cmd.rd_probe = 1'b1;
          state_next   = ST_PROBE_USE;
        end
      end
      ST_PROBE_USE: begin
        cmd.ld_probe = 1'b1;
        state_next   = ST_PROBE_RD;
      end
      ST_CHECK: begin
        if (sts.leaf) begin
          cmd.rd_sym = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/sfd_datapath.sv @@
module sfd_datapath
  import sfd_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int SUM_BITS    = DEF_SUM_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [OP_W-1:0]          in_op,
  input  logic [SYM_W-1:0]         in_sym,
  input  logic [ENTRY_COUNT_W-1:0] in_cnt,
  input  logic                     in_bit,
  input  logic                     m_tready,
  output logic                     out_valid,
  output logic                     out_status,
  output logic [SYM_W-1:0]         out_sym
);

  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  // Sums cannot wrap when the width covers every count of a full table;
  // then the prefix sums are monotone and a bisection finds the split.
  localparam bit BISECT = (SUM_BITS >= ENTRY_COUNT_W + IDX_W);

  logic [SYM_W-1:0]    sym_mem [MAX_SYMBOLS];
  logic [SUM_BITS-1:0] ps_mem  [MAX_SYMBOLS];

  logic [OP_W-1:0]          op;
  logic [SYM_W-1:0]         sym;
  logic [ENTRY_COUNT_W-1:0] cnt;
  logic                     bit_q;

  logic [CNT_W-1:0]    table_size;
  logic [IDX_W-1:0]    range_low;
  logic [IDX_W-1:0]    range_high;
  logic [SUM_BITS-1:0] last_sum;
  logic [SUM_BITS-1:0] base;
  logic [SUM_BITS-1:0] half;
  logic [SUM_BITS-1:0] ps_q;
  logic [SYM_W-1:0]    sym_q;
  logic [IDX_W-1:0]    s_lo;
  logic [IDX_W-1:0]    s_hi;

  logic [IDX_W-1:0]    full_high;
  logic [IDX_W:0]      probe_sum;
  logic [IDX_W-1:0]    probe;
  logic [IDX_W-1:0]    rd_addr;
  logic [SUM_BITS-1:0] new_sum;
  logic [SUM_BITS-1:0] rel_sum;
  logic [SUM_BITS-1:0] total;
  logic                hit;
  logic [IDX_W-1:0]    mid;
  logic                stale;

  assign full_high = (table_size == '0) ? '0 : IDX_W'(table_size - 1'b1);
  assign probe_sum = {1'b0, s_lo} + {1'b0, s_hi};
  assign probe     = BISECT ? probe_sum[IDX_W:1] : s_lo;
  assign new_sum   = last_sum + SUM_BITS'(cnt);
  assign rel_sum   = ps_q - base;
  assign total     = ps_q - base;
  assign hit       = (rel_sum >= half);
  assign mid       = (s_lo >= range_high) ? (range_high - 1'b1) : s_lo;
  assign stale     = ({1'b0, range_high} >= (IDX_W+1)'(table_size)) ||
                     (range_low >= range_high);

  always_comb begin
    rd_addr = probe;
    if (cmd.rd_base) begin
      rd_addr = range_low - 1'b1;
    end else if (cmd.rd_tot) begin
      rd_addr = range_high;
    end
  end

  // Table storage: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      sym_mem[table_size[IDX_W-1:0]] <= sym;
      ps_mem[table_size[IDX_W-1:0]]  <= new_sum;
    end
    if (cmd.rd_base || cmd.rd_tot || cmd.rd_probe) begin
      ps_q <= ps_mem[rd_addr];
    end
    if (cmd.rd_sym) begin
      sym_q <= sym_mem[range_low];
    end
  end

  // Request capture and search registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_op;
      sym   <= in_sym;
      cnt   <= in_cnt;
      bit_q <= in_bit;
    end
    if (cmd.rd_tot) begin
      base <= (range_low == '0) ? '0 : ps_q;
    end
    if (cmd.ld_tot) begin
      half <= total >> 1;
      s_lo <= range_low;
      s_hi <= range_high;
    end
    if (cmd.ld_probe) begin
      if (hit) begin
        s_hi <= BISECT ? probe : s_lo;
      end else begin
        s_lo <= probe + 1'b1;
      end
    end
  end

  // Table and range state.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
      range_low  <= '0;
      range_high <= '0;
      last_sum   <= '0;
    end else begin
      if (cmd.clear) begin
        table_size <= '0;
        range_low  <= '0;
        range_high <= '0;
        last_sum   <= '0;
      end else if (cmd.append) begin
        table_size <= table_size + 1'b1;
        last_sum   <= new_sum;
        range_low  <= '0;
        range_high <= table_size[IDX_W-1:0];
      end else if (cmd.fix_range) begin
        if (stale) begin
          range_low  <= '0;
          range_high <= full_high;
        end
      end else if (cmd.step) begin
        if (bit_q) begin
          range_low <= mid + 1'b1;
        end else begin
          range_high <= mid;
        end
      end else if (cmd.emit && op == OP_DECODE) begin
        range_low  <= '0;
        range_high <= full_high;
      end
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= (op == OP_APPEND);
      out_sym    <= (op == OP_APPEND) ? '0 : sym_q;
    end
  end

  always_comb begin
    sts.op          = op;
    sts.size_lt2    = (table_size < CNT_W'(2));
    sts.full        = (table_size == CNT_W'(MAX_SYMBOLS));
    sts.search_done = (s_lo == s_hi);
    sts.leaf        = (range_low == range_high);
    sts.out_free    = !out_valid || m_tready;
  end

endmodule

@@ rtl/core/shannon_fano_decoder_top.sv @@
// Clear and append return to idle from execute; a rejected append (table full)
//   goes on to load its result into the output register.
// Decode bit: the base and the range total are read, then the prefix-sum table is probed
//   through its one registered read port; bisection needs ceil(log2(range size)) probes;
//   a symbol that leaves is read and loaded into the output register; narrower sums scan linearly.
// Reset (rst, synchronous): empties the table and the range, drops any result.
module shannon_fano_decoder_top
  import sfd_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int SUM_BITS    = DEF_SUM_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request stream in.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // entry_symbol[7:0], entry_count[38:8], code_bit[39]
  input  logic [S_TUSER_W-1:0] s_tuser,  // opcode[1:0]
  // Result stream out.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // decoded_symbol[7:0]
  output logic [M_TUSER_W-1:0] m_tuser   // status[0]
);

  cmd_t cmd;
  sts_t sts;

  logic             out_status;
  logic [SYM_W-1:0] out_sym;

  // Sequencer: walks one request through the table reads and the search.
  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table storage, range registers, split search and output register.
  sfd_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .SUM_BITS    (SUM_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_tuser[OP_W-1:0]),
    .in_sym     (s_tdata[SYM_W-1:0]),
    .in_cnt     (s_tdata[SYM_W +: ENTRY_COUNT_W]),
    .in_bit     (s_tdata[SYM_W + ENTRY_COUNT_W]),
    .m_tready   (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_sym    (out_sym)
  );

  assign m_tdata    = out_sym;
  assign m_tuser[0] = out_status;

endmodule

@@ tb/sv/shannon_fano_decoder_top_tb.sv @@
`timescale 1ns / 100ps

module shannon_fano_decoder_top_tb;
  import sfd_pkg::*;

  localparam int                   TBL_DEPTH   = DEF_MAX_SYMBOLS;
  localparam int                   PSUM_W      = DEF_SUM_BITS;
  localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
  localparam logic                 RES_SYMBOL  = 1'b0;
  localparam logic                 RES_FULL    = 1'b1;
  localparam logic [30:0]          COUNT_MAX   = 31'h7FFF_FFFF;
  localparam int                   DIR_N       = 25;
  localparam int                   ITEM_TOTAL  = 400;
  localparam int                   QUIET_LIMIT = 3000;
  localparam int                   DRAIN_CYC   = 40;

  typedef struct packed {
    logic            status;
    logic [SYM_W-1:0] sym;
  } res_t;

  // One request, plus an optional typed-in result that overrides the
  // tree walk for rows whose outcome is obvious.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [SYM_W-1:0]         sym;
    logic [ENTRY_COUNT_W-1:0] cnt;
    logic                     code_bit;
    logic                     fixed;
    logic                     fx_n;
    res_t                     fx;
  } req_t;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  shannon_fano_decoder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // entry_symbol[7:0], entry_count[38:8], code_bit[39]
    .s_tuser  (s_tuser),   // opcode[1:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // decoded_symbol[7:0]
    .m_tuser  (m_tuser)    // status[0]
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Code table mirror: symbols, running prefix sums and the walk range.
  logic [SYM_W-1:0]  tbl_sym  [TBL_DEPTH];
  logic [PSUM_W-1:0] tbl_psum [TBL_DEPTH];
  int                tbl_len = 0;
  int                lo      = 0;
  int                hi      = 0;

  // Both queues fill at the front and drain from the back.
  req_t stim_q[$];
  res_t due_q[$];
  req_t cur;
  req_t dir_rows [DIR_N];
  int   issued      = 0;
  int   accepted    = 0;
  int   errors      = 0;
  int   quiet       = 0;
  int   cyc         = 0;
  int   walk_n;
  res_t walk_res;
  res_t got;
  res_t want;
  logic calm;

  // Walk one request through the code table; return how many results it
  // yields (0 or 1) and the result itself.
  function automatic int sf_walk(input req_t r, output res_t res);
    logic [PSUM_W-1:0] base;
    logic [PSUM_W-1:0] total;
    logic [PSUM_W-1:0] half;
    int                mid;
    res = '0;
    case (r.op)
      OP_CLEAR: begin
        tbl_len = 0;
        lo      = 0;
        hi      = 0;
        return 0;
      end
      OP_APPEND: begin
        if (tbl_len >= TBL_DEPTH) begin
          res.status = RES_FULL;
          return 1;
        end
        tbl_sym[tbl_len]  = r.sym;
        tbl_psum[tbl_len] = ((tbl_len == 0) ? '0 : tbl_psum[tbl_len-1]) + PSUM_W'(r.cnt);
        tbl_len++;
        lo = 0;
        hi = tbl_len - 1;
        return 0;
      end
      OP_DECODE: begin
        if (tbl_len < 2) return 0;
        // A range that slipped outside the table falls back to the full table.
        if (hi >= tbl_len || lo >= hi) begin
          lo = 0;
          hi = tbl_len - 1;
        end
        base  = (lo == 0) ? '0 : tbl_psum[lo-1];
        total = tbl_psum[hi] - base;
        half  = total >> 1;
        mid   = hi;
        for (int i = lo; i <= hi; i++) begin
          if (tbl_psum[i] - base >= half) begin
            mid = i;
            break;
          end
        end
        // Keep both halves non-empty when the split lands on the top entry.
        if (mid >= hi) mid = hi - 1;
        if (r.code_bit) lo = mid + 1;
        else hi = mid;
        if (lo == hi) begin
          res.status = RES_SYMBOL;
          res.sym    = tbl_sym[lo];
          lo = 0;
          hi = tbl_len - 1;
          return 1;
        end
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic req_t row(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                               input logic [30:0] cnt, input logic cb, input logic fx_n,
                               input logic fx_st, input logic [SYM_W-1:0] fx_sym);
    req_t r;
    r.op        = op;
    r.sym       = sym;
    r.cnt       = cnt;
    r.code_bit  = cb;
    r.fixed     = 1'b1;
    r.fx_n      = fx_n;
    r.fx.status = fx_st;
    r.fx.sym    = fx_sym;
    return r;
  endfunction

  function automatic req_t rq(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                              input logic [30:0] cnt, input logic cb);
    req_t r;
    r       = row(op, sym, cnt, cb, 1'b0, RES_SYMBOL, '0);
    r.fixed = 1'b0;
    return r;
  endfunction

  // Frequencies: zeros, maxima, small values and full-width random values.
  function automatic logic [30:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COUNT_MAX;
      2:       return 31'($urandom_range(1, 15));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic req_t rand_decode();
    return rq(OP_DECODE, 8'($urandom()), 31'($urandom()), 1'($urandom()));
  endfunction

  // Queue one request; drop it once the stimulus budget is spent.
  task automatic add(input req_t r);
    if (stim_q.size() < ITEM_TOTAL) stim_q.push_front(r);
  endtask

  task automatic report(input string what, input res_t w, input res_t g);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected status %0d symbol %02h, got status %0d symbol %02h",
               $realtime, what, w.status, w.sym, g.status, g.sym);
  endtask

  // Hold both sides busy-free during a stretch in the middle of the run.
  assign calm = (cyc >= 300 && cyc < 1500);

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      cyc++;
      quiet++;
      // Result side: compare against the oldest pending result.
      if (m_tvalid && m_tready) begin
        quiet      = 0;
        got.status = m_tuser[0];
        got.sym    = m_tdata;
        if (due_q.size() == 0) begin
          report("result with nothing pending", '0, got);
        end else begin
          want = due_q.pop_back();
          if (got.status != want.status || got.sym != want.sym)
            report("result mismatch", want, got);
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 11);

      // Request side: predict on accept, then present the next request.
      if (s_tvalid && s_tready) begin
        quiet  = 0;
        accepted++;
        walk_n = sf_walk(cur, walk_res);
        if (cur.fixed) begin
          if (cur.fx_n) due_q.push_front(cur.fx);
        end else if (walk_n != 0) begin
          due_q.push_front(walk_res);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (stim_q.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
          cur      = stim_q.pop_back();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur.code_bit, cur.cnt, cur.sym};
          s_tuser  <= cur.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end

      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int n_ent;
    int n_bits;
    int sel;

    // Directed rows: first ten carry typed-in results, the rest go
    // through the tree walk.
    dir_rows = '{
      row(OP_DECODE, 8'h00, '0,        1'b0, 1'b0, RES_SYMBOL, 8'h00), // empty table
      row(OP_DECODE, 8'hFF, COUNT_MAX, 1'b1, 1'b0, RES_SYMBOL, 8'h00),
      row(OP_UNUSED, 8'hFF, COUNT_MAX, 1'b1, 1'b0, RES_SYMBOL, 8'h00), // ignored
      row(OP_APPEND, 8'hFF, COUNT_MAX, 1'b0, 1'b0, RES_SYMBOL, 8'h00),
      row(OP_DECODE, 8'h00, '0,        1'b1, 1'b0, RES_SYMBOL, 8'h00), // one entry
      row(OP_APPEND, 8'h00, '0,        1'b1, 1'b0, RES_SYMBOL, 8'h00),
      row(OP_DECODE, 8'h00, '0,        1'b0, 1'b1, RES_SYMBOL, 8'hFF),
      row(OP_DECODE, 8'h00, '0,        1'b1, 1'b1, RES_SYMBOL, 8'h00),
      row(OP_CLEAR,  8'hFF, COUNT_MAX, 1'b1, 1'b0, RES_SYMBOL, 8'h00),
      row(OP_DECODE, 8'h00, '0,        1'b1, 1'b0, RES_SYMBOL, 8'h00), // cleared
      // Ascending counts force the split onto the top entry.
      rq(OP_APPEND, 8'h41, 31'd1,  1'b0),
      rq(OP_APPEND, 8'h42, 31'd1,  1'b0),
      rq(OP_APPEND, 8'h43, 31'd10, 1'b0),
      rq(OP_DECODE, 8'h00, '0, 1'b1),
      rq(OP_DECODE, 8'h00, '0, 1'b0),
      rq(OP_DECODE, 8'h00, '0, 1'b0),
      rq(OP_DECODE, 8'h00, '0, 1'b1),
      // Zero-count entries appended to a table that already holds entries.
      rq(OP_APPEND, 8'h44, '0, 1'b0),
      rq(OP_APPEND, 8'h45, '0, 1'b0),
      rq(OP_DECODE, 8'h00, '0, 1'b0),
      rq(OP_DECODE, 8'h00, '0, 1'b0),
      rq(OP_DECODE, 8'h00, '0, 1'b1),
      rq(OP_DECODE, 8'h00, '0, 1'b1),
      rq(OP_DECODE, 8'h00, '0, 1'b1),
      rq(OP_UNUSED, 8'h00, '0, 1'b0)
    };
    for (int i = 0; i < DIR_N; i++) stim_q.push_front(dir_rows[i]);

    // Fill the table to capacity, overflow it twice, then walk the full tree.
    stim_q.push_front(rq(OP_CLEAR, '0, '0, 1'b0));
    for (int i = 0; i < TBL_DEPTH; i++)
      stim_q.push_front(rq(OP_APPEND, 8'($urandom()),
                           (i % 4 == 0) ? COUNT_MAX : pick_count(), 1'b0));
    stim_q.push_front(row(OP_APPEND, 8'hAB, 31'd5,     1'b0, 1'b1, RES_FULL, 8'h00));
    stim_q.push_front(row(OP_APPEND, 8'hFF, COUNT_MAX, 1'b1, 1'b1, RES_FULL, 8'h00));
    for (int i = 0; i < 40; i++) stim_q.push_front(rand_decode());

    // Random part: mostly clear / header / bit-stream sequences, with
    // mid-stream appends and some loose noise requests.
    while (stim_q.size() < ITEM_TOTAL) begin
      if ($urandom_range(0, 99) < 85) begin
        sel   = $urandom_range(0, 19);
        n_ent = (sel == 0) ? $urandom_range(0, 1) :
                (sel == 1) ? $urandom_range(13, 48) : $urandom_range(2, 12);
        add(rq(OP_CLEAR, 8'($urandom()), 31'($urandom()), 1'($urandom())));
        for (int i = 0; i < n_ent; i++)
          add(rq(OP_APPEND, 8'($urandom()), pick_count(), 1'($urandom())));
        n_bits = $urandom_range(n_ent + 2, 3 * n_ent + 4);
        for (int i = 0; i < n_bits; i++) begin
          if ($urandom_range(0, 99) < 3)
            add(rq(OP_APPEND, 8'($urandom()), pick_count(), 1'($urandom())));
          add(rand_decode());
        end
      end else begin
        repeat ($urandom_range(1, 4))
          add(rq(2'($urandom()), 8'($urandom()), 31'($urandom()), 1'($urandom())));
      end
    end
    issued = stim_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests taken, all symbols back, then a quiet tail.
    while (accepted < issued) @(posedge clk);
    while (due_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sfd_pkg.sv
rtl/core/sfd_ctrl.sv
rtl/core/sfd_datapath.sv
rtl/core/shannon_fano_decoder_top.sv
tb/sv/shannon_fano_decoder_top_tb.sv
